// File: rtl/bws_pkg.sv
// bilinear window sampler: shared types, sizes and grid constants
// no dependencies; used by the lane, merge and top-level modules of the block
package bws_pkg;

    // window and grid geometry
    localparam int WINDOW_SIZE = 8;
    localparam int LANES       = WINDOW_SIZE - 1;
    localparam int HALF_OFF    = WINDOW_SIZE / 2 - 1;
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 48;

    // fixed point layout
    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 6;
    localparam int WEIGHT_W = 2 * FRAC_W + 1;
    localparam int PROD_W   = WEIGHT_W + 1 + SAMPLE_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int CELL_W   = 12;
    localparam int COL_W    = $clog2(WINDOW_SIZE);
    localparam int ROUND_SH = 2 * FRAC_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [COL_W-1:0]           t_col;

    // four bilinear weights, Q.12, they sum to one
    typedef struct packed {
        logic [WEIGHT_W-1:0] w0;
        logic [WEIGHT_W-1:0] w1;
        logic [WEIGHT_W-1:0] w2;
        logic [WEIGHT_W-1:0] w3;
    } t_weights;

    // stage strobes from the sequencer to the lanes
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } t_lane_ctrl;

    // status of the result serializer back to the sequencer
    typedef struct packed {
        logic final_load;
    } t_merge_stat;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_SUM  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

// File: rtl/bws_lane.sv
// bilinear window sampler: one interpolation lane (2x2 weighted sum)
// depends on bws_pkg
module bws_lane (
    input  logic                   i_clk,
    input  bws_pkg::t_lane_ctrl    i_ctrl,
    input  bws_pkg::t_weights      i_w,
    input  bws_pkg::t_sample       i_prev_a,
    input  bws_pkg::t_sample       i_prev_b,
    input  bws_pkg::t_sample       i_cur_a,
    input  bws_pkg::t_sample       i_cur_b,
    output bws_pkg::t_sample       o_value
);

    logic signed [bws_pkg::PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [bws_pkg::ACC_W-1:0]  acc;
    logic signed [bws_pkg::ACC_W-1:0]  rnd;
    logic signed [bws_pkg::ACC_W-1:0]  quo;
    bws_pkg::t_sample                  n_value;
    bws_pkg::t_sample                  r_value;

    // product stage, one multiplier per term
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_p0 <= $signed({1'b0, i_w.w0}) * i_prev_a;
            r_p1 <= $signed({1'b0, i_w.w1}) * i_prev_b;
            r_p2 <= $signed({1'b0, i_w.w2}) * i_cur_a;
            r_p3 <= $signed({1'b0, i_w.w3}) * i_cur_b;
        end
    end

    // add, round half up, saturate
    always_comb begin
        acc = bws_pkg::ACC_W'(r_p0) + bws_pkg::ACC_W'(r_p1)
            + bws_pkg::ACC_W'(r_p2) + bws_pkg::ACC_W'(r_p3);
        rnd = acc + bws_pkg::ACC_W'(2048);
        quo = rnd >>> bws_pkg::ROUND_SH;
        if (quo > bws_pkg::ACC_W'(32767)) begin
            n_value = 16'sh7FFF;
        end else if (quo < -(bws_pkg::ACC_W'(32768))) begin
            n_value = 16'sh8000;
        end else begin
            n_value = quo[bws_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sum_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// File: rtl/bws_merge.sv
// bilinear window sampler: merges the lane results into one result stream
// depends on bws_pkg
module bws_merge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  bws_pkg::t_col          i_row,
    input  bws_pkg::t_sample       i_res [bws_pkg::LANES],
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output bws_pkg::t_sample       o_value,
    output bws_pkg::t_col          o_out_row,
    output bws_pkg::t_col          o_out_col,
    output logic                   o_last,
    output bws_pkg::t_merge_stat   o_stat
);

    localparam bws_pkg::t_col LAST_COL = bws_pkg::COL_W'(bws_pkg::LANES - 1);

    logic             r_pend;
    bws_pkg::t_col    r_col;
    logic             r_valid;
    bws_pkg::t_sample r_value;
    bws_pkg::t_col    r_orow;
    bws_pkg::t_col    r_ocol;
    logic             r_last;
    logic             load;

    // next column moves into the output register when it is free or drains
    assign load = r_pend && (!r_valid || !i_out_stall);

    // serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_start) begin
                r_pend <= 1'b1;
                r_col  <= '0;
            end else if (load) begin
                if (r_col == LAST_COL) begin
                    r_pend <= 1'b0;
                end
                r_col <= r_col + 1'b1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= i_res[r_col];
            r_orow  <= i_row;
            r_ocol  <= r_col;
            r_last  <= (r_col == LAST_COL);
        end
    end

    assign o_out_valid       = r_valid;
    assign o_value           = r_value;
    assign o_out_row         = r_orow;
    assign o_out_col         = r_ocol;
    assign o_last            = r_last;
    assign o_stat.final_load = load && (r_col == LAST_COL);

endmodule

// File: rtl/bilinear_window_sampler.sv
// bilinear window sampler top level: front end, sequencer, lanes, merge
// depends on bws_pkg, bws_lane, bws_merge
//
//   channel | direction | handshake                     | payload
//   --------+-----------+-------------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall       | coord_x, coord_y, window_row,
//           |           |                               | sample_0 .. sample_7
//   out     | output    | o_out_valid / i_out_stall     | value, out_row, out_col, last
//   cfg     | input     | i_cfg_we                      | i_cfg_wdata (scale)
//
// an item with window_row 0 goes through accept, multiply and sum
// a row of 1 to 7 goes through accept, multiply, sum, then 7 result loads out
// of the lane result registers, one per cycle when out is not stalled
// the output register lets the next item be accepted while the last result waits
// synchronous active-low reset clears the sequencer, scale and output valid
// the stored previous row is undefined until the first accepted row has passed the sum state
module bilinear_window_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [15:0] i_coord_x,
    input  logic signed [15:0] i_coord_y,
    input  logic [2:0]  i_window_row,
    input  logic signed [15:0] i_sample_0,
    input  logic signed [15:0] i_sample_1,
    input  logic signed [15:0] i_sample_2,
    input  logic signed [15:0] i_sample_3,
    input  logic signed [15:0] i_sample_4,
    input  logic signed [15:0] i_sample_5,
    input  logic signed [15:0] i_sample_6,
    input  logic signed [15:0] i_sample_7,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [15:0] o_value,
    output logic [2:0]  o_out_row,
    output logic [2:0]  o_out_col,
    output logic        o_last
);

    localparam int WS = bws_pkg::WINDOW_SIZE;
    localparam int CW = bws_pkg::CELL_W;
    localparam int FW = bws_pkg::FRAC_W;

    bws_pkg::t_state      r_state, n_state;
    logic [1:0]           r_scale;
    logic                 accept;

    logic signed [15:0]   sx, sy;
    logic signed [CW-1:0] x_id, y_id, ry, x_lim, y_lim;
    logic signed [CW-1:0] cx [WS];
    logic [FW:0]          ax, ay, bx, by;
    logic                 row_in;
    bws_pkg::t_sample     in_samp [WS];
    bws_pkg::t_sample     n_cur [WS];
    bws_pkg::t_weights    n_w;

    bws_pkg::t_sample     r_cur [WS];
    bws_pkg::t_sample     r_prev [WS];
    bws_pkg::t_weights    r_w;
    bws_pkg::t_col        r_row;

    bws_pkg::t_lane_ctrl  lane_ctrl;
    bws_pkg::t_sample     lane_res [bws_pkg::LANES];
    bws_pkg::t_merge_stat merge_stat;
    logic                 merge_start;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != bws_pkg::S_IDLE);

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
        end else if (i_cfg_we) begin
            r_scale <= i_cfg_wdata;
        end
    end

    assign in_samp[0] = i_sample_0;
    assign in_samp[1] = i_sample_1;
    assign in_samp[2] = i_sample_2;
    assign in_samp[3] = i_sample_3;
    assign in_samp[4] = i_sample_4;
    assign in_samp[5] = i_sample_5;
    assign in_samp[6] = i_sample_6;
    assign in_samp[7] = i_sample_7;

    // scale, split into cell and fraction, weights and grid mask
    always_comb begin
        sx     = i_coord_x >>> r_scale;
        sy     = i_coord_y >>> r_scale;
        x_id   = CW'($signed(sx[15:FW]));
        y_id   = CW'($signed(sy[15:FW]));
        bx     = {1'b0, sx[FW-1:0]};
        by     = {1'b0, sy[FW-1:0]};
        ax     = (FW+1)'(64) - bx;
        ay     = (FW+1)'(64) - by;
        n_w.w0 = {6'd0, ax} * {6'd0, ay};
        n_w.w1 = {6'd0, bx} * {6'd0, ay};
        n_w.w2 = {6'd0, ax} * {6'd0, by};
        n_w.w3 = {6'd0, bx} * {6'd0, by};
        x_lim  = CW'(bws_pkg::GRID_WIDTH >> r_scale);
        y_lim  = CW'(bws_pkg::GRID_HEIGHT >> r_scale);
        ry     = y_id + CW'(i_window_row) - CW'(bws_pkg::HALF_OFF);
        row_in = (ry >= 0) && (ry < y_lim);
        for (int c = 0; c < WS; c++) begin
            cx[c]    = x_id + CW'(c) - CW'(bws_pkg::HALF_OFF);
            n_cur[c] = (row_in && cx[c] >= 0 && cx[c] < x_lim) ? in_samp[c] : '0;
        end
    end

    // accepted row, weights and the stored previous row
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= n_cur;
            r_w   <= n_w;
            r_row <= i_window_row;
        end
        if (r_state == bws_pkg::S_SUM) begin
            r_prev <= r_cur;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bws_pkg::S_IDLE: begin
                if (accept) n_state = bws_pkg::S_MUL;
            end
            bws_pkg::S_MUL: begin
                n_state = bws_pkg::S_SUM;
            end
            bws_pkg::S_SUM: begin
                n_state = (r_row != '0) ? bws_pkg::S_EMIT : bws_pkg::S_IDLE;
            end
            bws_pkg::S_EMIT: begin
                if (merge_stat.final_load) n_state = bws_pkg::S_IDLE;
            end
            default: n_state = bws_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign lane_ctrl.mul_en = (r_state == bws_pkg::S_MUL);
    assign lane_ctrl.sum_en = (r_state == bws_pkg::S_SUM);
    assign merge_start      = (r_state == bws_pkg::S_SUM) && (r_row != '0);

    // one lane per result column
    for (genvar l = 0; l < bws_pkg::LANES; l++) begin : g_lane
        bws_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (lane_ctrl),
            .i_w      (r_w),
            .i_prev_a (r_prev[l]),
            .i_prev_b (r_prev[l+1]),
            .i_cur_a  (r_cur[l]),
            .i_cur_b  (r_cur[l+1]),
            .o_value  (lane_res[l])
        );
    end

    // result serializer
    bws_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (merge_start),
        .i_row       (r_row - 1'b1),
        .i_res       (lane_res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last),
        .o_stat      (merge_stat)
    );

endmodule

// File: rtl/bws_checker.sv
// bilinear window sampler: port-level checker and its bind to the top level
// depends on bilinear_window_sampler port names only
module bws_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_value,
    input logic [2:0]  o_out_row,
    input logic [2:0]  o_out_col,
    input logic        o_last
);

    // a stalled result transaction holds its value, column and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value)
        && $stable(o_out_col) && $stable(o_last))
        else $error("stalled result changed");

    // last marks the final column only
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_col == 3'd6)
        else $error("last on wrong column");

    // a taken non-final result is followed at once by the next column of the row
    a_next_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid
        && o_out_col == $past(o_out_col) + 3'd1 && $stable(o_out_row))
        else $error("result run broken");

    // no new row is taken while the current run still has results to show
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("input taken mid run");

endmodule

bind bilinear_window_sampler bws_props u_bws_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_last      (o_last)
);
